// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_dpath and sorted_priority_queue; no dependencies.
package spq_pkg;

	// Operation selector carried on the input tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status carried on the output tuser
	typedef logic [1:0] status_t;
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture the accepted input item
		logic mul;    // form the key from id and urgency
		logic exec;   // update the cell chain and load the result register
	} dp_cmd_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// Controller for the sorted priority queue: sequences load, key multiply
// and execute steps and owns the stream handshakes. Depends on spq_pkg.
module spq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output spq_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   exec_ok;

	// Execute only when the result register is free or drains this cycle
	assign exec_ok = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign cmd.load = in_valid && ready_q;
	assign cmd.mul  = (state_q == S_MUL);
	assign cmd.exec = exec_ok;

	assign in_ready  = ready_q;
	assign out_valid = out_valid_q;

	// Hold state, input ready and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the result is taken
			if (exec_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= S_MUL;
						ready_q <= 1'b0;
					end
				end
				S_MUL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_ok) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hdl/spq_dpath.sv =====
// Datapath for the sorted priority queue: input capture, key multiplier,
// the sorted cell chain, entry count and result register. Depends on spq_pkg.
module spq_dpath #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int ID_BITS      = 16,
	parameter int URGENCY_BITS = 8,
	parameter int KEY_BITS     = ID_BITS + URGENCY_BITS,
	parameter int CNT_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_pkg::dp_cmd_t        cmd,
	input  logic                    in_op,
	input  logic [ID_BITS-1:0]      in_id,
	input  logic [URGENCY_BITS-1:0] in_urgency,
	output spq_pkg::status_t        res_status,
	output logic [ID_BITS-1:0]      res_id,
	output logic [KEY_BITS-1:0]     res_key,
	output logic [CNT_BITS-1:0]     res_occupancy
);

	// Captured operation
	logic                    op_q;
	logic [ID_BITS-1:0]      id_q;
	logic [URGENCY_BITS-1:0] urg_q;
	logic [KEY_BITS-1:0]     key_q;

	// Cell chain: cell 0 holds the largest key, keys descend toward the end
	logic [KEY_BITS-1:0] cell_key_q [QUEUE_DEPTH];
	logic [ID_BITS-1:0]  cell_id_q  [QUEUE_DEPTH];
	logic [CNT_BITS-1:0] cnt_q;

	logic [QUEUE_DEPTH-1:0] stay;
	logic                   full;
	logic                   empty;

	// Result register
	spq_pkg::status_t    status_q;
	logic [ID_BITS-1:0]  rid_q;
	logic [KEY_BITS-1:0] rkey_q;
	logic [CNT_BITS-1:0] rocc_q;

	assign full  = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);

	// Mark occupied cells whose key exceeds the new key; they keep their place
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			stay[i] = (CNT_BITS'(i) < cnt_q) && (cell_key_q[i] > key_q);
		end
	end

	// Capture the item and form its key
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			id_q  <= in_id;
			urg_q <= in_urgency;
		end
		if (cmd.mul) begin
			key_q <= KEY_BITS'(id_q) * KEY_BITS'(urg_q);
		end
	end

	// Shift the cell chain on insert or remove
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == spq_pkg::OP_INSERT) begin
				if (!full) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						if (!stay[i]) begin
							if (i == 0) begin
								cell_key_q[i] <= key_q;
								cell_id_q[i]  <= id_q;
							end else if (stay[(i == 0) ? 0 : i - 1]) begin
								cell_key_q[i] <= key_q;
								cell_id_q[i]  <= id_q;
							end else begin
								cell_key_q[i] <= cell_key_q[(i == 0) ? 0 : i - 1];
								cell_id_q[i]  <= cell_id_q[(i == 0) ? 0 : i - 1];
							end
						end
					end
				end
			end else if (!empty) begin
				for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
					cell_key_q[i] <= cell_key_q[i + 1];
					cell_id_q[i]  <= cell_id_q[i + 1];
				end
			end
		end
	end

	// Track the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == spq_pkg::OP_INSERT) begin
				if (!full) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
			end else if (!empty) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == spq_pkg::OP_INSERT) begin
				status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				rid_q    <= id_q;
				rkey_q   <= key_q;
				rocc_q   <= full ? cnt_q : cnt_q + CNT_BITS'(1);
			end else if (empty) begin
				status_q <= spq_pkg::ST_EMPTY;
				rid_q    <= '0;
				rkey_q   <= '0;
				rocc_q   <= '0;
			end else begin
				status_q <= spq_pkg::ST_DONE;
				rid_q    <= cell_id_q[0];
				rkey_q   <= cell_key_q[0];
				rocc_q   <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	assign res_status    = status_q;
	assign res_id        = rid_q;
	assign res_key       = rkey_q;
	assign res_occupancy = rocc_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue, one operation at a time: accepting an item loads it,
// then the urgency-times-id key is registered, then the execute step updates
// the cell chain and loads the result register (valid then) once it is free.
// A new item is taken while the previous result waits on the output.
// Reset clears the entry count and handshakes; stored entries stay undefined.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int ID_BITS      = 16,
	parameter int URGENCY_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// item_id, urgency (from bit 0 up), zero padding to whole bytes
	input  logic [((ID_BITS + URGENCY_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// operation
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_id, result_key, occupancy (from bit 0 up), zero padding
	output logic [((2 * ID_BITS + URGENCY_BITS + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
		m_axis_tdata,
	// status
	output spq_pkg::status_t m_axis_tuser
);

	localparam int KEY_BITS    = ID_BITS + URGENCY_BITS;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int M_DATA_BITS = ((ID_BITS + KEY_BITS + CNT_BITS + 7) / 8) * 8;

	spq_pkg::dp_cmd_t    cmd;
	logic [ID_BITS-1:0]  res_id;
	logic [KEY_BITS-1:0] res_key;
	logic [CNT_BITS-1:0] res_occ;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	spq_dpath #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.ID_BITS      (ID_BITS),
		.URGENCY_BITS (URGENCY_BITS),
		.KEY_BITS     (KEY_BITS),
		.CNT_BITS     (CNT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_op         (s_axis_tuser),
		.in_id         (s_axis_tdata[ID_BITS-1:0]),
		.in_urgency    (s_axis_tdata[ID_BITS +: URGENCY_BITS]),
		.res_status    (m_axis_tuser),
		.res_id        (res_id),
		.res_key       (res_key),
		.res_occupancy (res_occ)
	);

	// Pack the result fields, zero padded
	assign m_axis_tdata = M_DATA_BITS'({res_occ, res_key, res_id});

endmodule
